// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the commutation detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// ----- hw/rtl/bssc_pkg.sv -----
// Package of types, constants and functions for the six-step commutation detector.
`timescale 1ns / 1ps
`default_nettype none
package bssc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned StepW   = 3;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SampleW-1:0] HighThreshReset = 12'd2200;
  localparam logic [SampleW-1:0] LowThreshReset  = 12'd1300;

  localparam logic [PhaseW-1:0] PhaseNone = 2'd0;
  localparam logic [PhaseW-1:0] PhaseU    = 2'd1;
  localparam logic [PhaseW-1:0] PhaseV    = 2'd2;
  localparam logic [PhaseW-1:0] PhaseW3   = 2'd3;

  localparam logic [StepW-1:0] StepFirst = 3'd1;
  localparam logic [StepW-1:0] StepLast  = 3'd6;

  localparam logic [CfgIdxW-1:0] RegHighThresh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLowThresh  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRunning    = 2'd2;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic               commutate;
    logic [StepW-1:0]   step_now;
    logic [PhaseW-1:0]  next_phase;
    logic [CountW-1:0]  commutation_total;
  } out_t;

  typedef struct packed {
    logic [SampleW-1:0] high_threshold;
    logic [SampleW-1:0] low_threshold;
    logic               running;
  } cfg_t;

  // Phase to sample while a given step is active.
  function automatic logic [PhaseW-1:0] phase_of_step(input logic [StepW-1:0] s);
    logic [PhaseW-1:0] p;
    case (s)
      3'd1:    p = PhaseV;
      3'd2:    p = PhaseU;
      3'd3:    p = PhaseW3;
      3'd4:    p = PhaseV;
      3'd5:    p = PhaseU;
      3'd6:    p = PhaseW3;
      default: p = PhaseU;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bssc_cfg.sv -----
// Configuration register file: thresholds and the running enable.
`timescale 1ns / 1ps
`default_nettype none
module bssc_cfg
  import bssc_pkg::*;
#(
  parameter logic [SampleW-1:0] HIGH_RESET = HighThreshReset,
  parameter logic [SampleW-1:0] LOW_RESET  = LowThreshReset
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [SampleW-1:0] wr_data,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold <= HIGH_RESET;
      cfg.low_threshold  <= LOW_RESET;
      cfg.running        <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegHighThresh: cfg.high_threshold <= wr_data;
        RegLowThresh:  cfg.low_threshold  <= wr_data;
        RegRunning:    cfg.running        <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bssc_core.sv -----
// Phase levels, step sequencer, commutation counter and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bssc_core
  import bssc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic item_valid,
  output logic      item_ready,
  input  wire in_t  item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic [SampleW-1:0] level_u, level_v, level_w;
  logic [SampleW-1:0] level_u_next, level_v_next, level_w_next;
  logic [StepW-1:0]   step, step_next;
  logic [CountW-1:0]  step_count, step_count_next;
  logic               edge_hit;
  logic               fire;
  logic               take;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    level_u_next = level_u;
    level_v_next = level_v;
    level_w_next = level_w;
    case (item.phase)
      PhaseU:  level_u_next = item.sample;
      PhaseV:  level_v_next = item.sample;
      PhaseW3: level_w_next = item.sample;
      default: ;
    endcase
  end

  // The test looks at the levels as they stand after this sample is stored.
  always_comb begin
    unique case (step)
      3'd1:    edge_hit = level_w_next > cfg.high_threshold;
      3'd2:    edge_hit = level_v_next < cfg.low_threshold;
      3'd3:    edge_hit = level_u_next > cfg.high_threshold;
      3'd4:    edge_hit = level_w_next < cfg.low_threshold;
      3'd5:    edge_hit = level_v_next > cfg.high_threshold;
      3'd6:    edge_hit = level_u_next < cfg.low_threshold;
      default: edge_hit = 1'b0;
    endcase
  end

  assign fire = cfg.running && edge_hit;

  always_comb begin
    step_next       = step;
    step_count_next = step_count;
    if (fire) begin
      step_next       = (step >= StepLast) ? StepFirst : step + 3'd1;
      step_count_next = step_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_u    <= '0;
      level_v    <= '0;
      level_w    <= '0;
      step       <= StepFirst;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        level_u    <= level_u_next;
        level_v    <= level_v_next;
        level_w    <= level_w_next;
        step       <= step_next;
        step_count <= step_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.commutate         <= fire;
      out_data.step_now          <= step_next;
      out_data.next_phase        <= phase_of_step(step_next);
      out_data.commutation_total <= step_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bemf_six_step_commutation_detect_top.sv -----
// Top level of the six-step back-EMF commutation detector.
// Each transaction on the input channel carries one back-EMF sample and its phase tag, and
// produces exactly one result transaction. An item passes an input register and then the
// result register; the threshold compare and step update sit between the two registers, and
// a new item is taken every cycle while the output side keeps up. Configuration registers
// (0 high threshold, 1 low threshold, 2 running) are written through the cfg channel, which
// is always ready; writes to index 3 are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bemf_six_step_commutation_detect_top
  import bssc_pkg::*;
#(
  parameter logic [SampleW-1:0] HIGH_RESET = HighThreshReset,
  parameter logic [SampleW-1:0] LOW_RESET  = LowThreshReset
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [SampleW-1:0] cfg_data
);

  cfg_t cfg;
  logic s1_valid;
  in_t  s1_data;
  logic core_ready;
  logic step_in_range;
  logic phase_matches;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || core_ready;

  bssc_cfg #(
    .HIGH_RESET(HIGH_RESET),
    .LOW_RESET (LOW_RESET)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  bssc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(s1_valid),
    .item_ready(core_ready),
    .item      (s1_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign step_in_range = out_data.step_now >= StepFirst && out_data.step_now <= StepLast;
  assign phase_matches = out_data.next_phase == phase_of_step(out_data.step_now);

  `ASSERT_CLK(a_step_range, !out_valid || step_in_range, "step out of range")
  `ASSERT_CLK(a_phase_match, !out_valid || phase_matches, "next phase does not match step")
  `ASSERT_NEXT(a_s1_hold, s1_valid && !core_ready, s1_valid && $stable(s1_data), "item lost")
  `ASSERT_CLK(a_idle_no_fire, !(out_valid && !cfg.running && out_data.commutate), "idle fire")

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the six-step back-EMF commutation detector.
`timescale 1ns / 1ps
module tb;
  import bssc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int MaxReports = 10;
  localparam int SampleMax = (1 << SampleW) - 1;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 205;

  typedef enum logic {ROW_ITEM, ROW_SETTINGS} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    in_t                item;
    bit                 typed;
    out_t               want;
    logic [SampleW-1:0] high;
    logic [SampleW-1:0] low;
    logic               run;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  in_t                in_data = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SampleW-1:0] cfg_data = '0;
  logic               in_ready;
  logic               out_valid;
  logic               cfg_ready;
  out_t               out_data;

  bemf_six_step_commutation_detect_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the detector's settings and state.
  logic [SampleW-1:0] thr_high;
  logic [SampleW-1:0] thr_low;
  logic               run_en;
  logic [SampleW-1:0] held_u;
  logic [SampleW-1:0] held_v;
  logic [SampleW-1:0] held_w;
  logic [StepW-1:0]   step_q;
  logic [CountW-1:0]  comm_count;

  out_t          pending_results[$];
  directed_row_t directed_rows[$];
  int            failures = 0;
  int            mismatches = 0;
  int            results_checked = 0;
  int            commutations_seen = 0;
  int            settings_applied = 0;
  int            stall_left = 0;
  bit            gaps_allowed = 1'b1;

  // Phase whose stored level decides the edge in a given step.
  function automatic logic [PhaseW-1:0] watched_phase(input logic [StepW-1:0] s);
    case (s)
      3'd1, 3'd4: return PhaseW3;
      3'd2, 3'd5: return PhaseV;
      default:    return PhaseU;
    endcase
  endfunction

  function automatic logic [PhaseW-1:0] phase_to_sample(input logic [StepW-1:0] s);
    case (s)
      3'd1, 3'd4: return PhaseV;
      3'd3, 3'd6: return PhaseW3;
      default:    return PhaseU;
    endcase
  endfunction

  function automatic void reset_model();
    thr_high   = HighThreshReset;
    thr_low    = LowThreshReset;
    run_en     = 1'b0;
    held_u     = '0;
    held_v     = '0;
    held_w     = '0;
    step_q     = StepFirst;
    comm_count = '0;
  endfunction

  function automatic out_t predict_commutation(input in_t item);
    out_t               res;
    logic [SampleW-1:0] lvl;
    logic               fire;
    case (item.phase)
      PhaseU:  held_u = item.sample;
      PhaseV:  held_v = item.sample;
      PhaseW3: held_w = item.sample;
      default: ;
    endcase
    case (watched_phase(step_q))
      PhaseU:  lvl = held_u;
      PhaseV:  lvl = held_v;
      default: lvl = held_w;
    endcase
    // Odd steps wait for a rising level, even steps for a falling one.
    fire = run_en && (step_q[0] ? (lvl > thr_high) : (lvl < thr_low));
    if (fire) begin
      step_q     = (step_q >= StepLast) ? StepFirst : step_q + 3'd1;
      comm_count = comm_count + 1'b1;
    end
    res.commutate         = fire;
    res.step_now          = step_q;
    res.next_phase        = phase_to_sample(step_q);
    res.commutation_total = comm_count;
    return res;
  endfunction

  function automatic void add_item(input logic [PhaseW-1:0] ph, input logic [SampleW-1:0] smp);
    directed_row_t row;
    row.kind        = ROW_ITEM;
    row.item.phase  = ph;
    row.item.sample = smp;
    row.typed       = 1'b0;
    row.want        = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [PhaseW-1:0] ph, input logic [SampleW-1:0] smp,
                                      input logic c, input logic [StepW-1:0] st,
                                      input logic [PhaseW-1:0] np, input logic [CountW-1:0] total);
    directed_row_t row;
    row.kind                   = ROW_ITEM;
    row.item.phase             = ph;
    row.item.sample            = smp;
    row.typed                  = 1'b1;
    row.want.commutate         = c;
    row.want.step_now          = st;
    row.want.next_phase        = np;
    row.want.commutation_total = total;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_settings(input logic [SampleW-1:0] h, input logic [SampleW-1:0] l,
                                       input logic r);
    directed_row_t row;
    row.kind = ROW_SETTINGS;
    row.high = h;
    row.low  = l;
    row.run  = r;
    directed_rows.push_back(row);
  endfunction

  // Mostly samples of the watched phase close to its threshold, some on the phase
  // the step asks for, and the rest plain noise.
  function automatic in_t random_item();
    in_t                item;
    int                 pick;
    int                 off;
    int                 level;
    logic [SampleW-1:0] base;
    pick        = $urandom_range(0, 99);
    item.phase  = PhaseW'($urandom_range(0, 3));
    item.sample = SampleW'($urandom);
    if (pick < 60) begin
      item.phase = watched_phase(step_q);
      base       = step_q[0] ? thr_high : thr_low;
      off        = $urandom_range(0, 16);
      level      = int'(base) + off - 8;
      if (level < 0) level = 0;
      else if (level > SampleMax) level = SampleMax;
      if ($urandom_range(0, 3) != 0) item.sample = SampleW'(level);
    end else if (pick < 75) begin
      item.phase = phase_to_sample(step_q);
    end
    return item;
  endfunction

  task automatic send_item(input in_t item, input bit typed, input out_t want);
    out_t pred;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pred = predict_commutation(item);
    pending_results.push_back(typed ? want : pred);
    if (gaps_allowed && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegHighThresh: thr_high = value;
      RegLowThresh:  thr_low  = value;
      RegRunning:    run_en   = value[0];
      default:       ;
    endcase
  endtask

  // Settings change only once every pending result has been taken.
  task automatic apply_settings(input logic [SampleW-1:0] high, input logic [SampleW-1:0] low,
                                input logic run);
    logic [SampleW-1:0] run_word;
    run_word    = SampleW'($urandom);
    run_word[0] = run;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(RegHighThresh, high);
    write_reg(RegLowThresh, low);
    write_reg(RegUnused, SampleW'($urandom));
    write_reg(RegRunning, run_word);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (mismatches < MaxReports)
            $display("Unexpected result transaction: commutate=%0d step=%0d total=%0d",
                     out_data.commutate, out_data.step_now, out_data.commutation_total);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_data.commutate) commutations_seen++;
          if (out_data.commutate !== want.commutate || out_data.step_now !== want.step_now ||
              out_data.next_phase !== want.next_phase ||
              out_data.commutation_total !== want.commutation_total) begin
            failures++;
            if (mismatches < MaxReports)
              $display({"Result %0d mismatch: expected commutate=%0d step=%0d next_phase=%0d ",
                        "total=%0d, got commutate=%0d step=%0d next_phase=%0d total=%0d"},
                       results_checked, want.commutate, want.step_now, want.next_phase,
                       want.commutation_total, out_data.commutate, out_data.step_now,
                       out_data.next_phase, out_data.commutation_total);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (gaps_allowed && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    out_t               no_want;
    logic [SampleW-1:0] h;
    logic [SampleW-1:0] l;
    logic               r;
    no_want = '0;
    reset_model();

    // Not running: levels are stored but the step holds.
    add_checked(PhaseU, 12'd4095, 1'b0, 3'd1, PhaseV, 0);
    add_checked(PhaseW3, 12'd4095, 1'b0, 3'd1, PhaseV, 0);
    add_checked(PhaseNone, 12'd0, 1'b0, 3'd1, PhaseV, 0);
    add_settings(12'd2200, 12'd1300, 1'b1);
    // With no phase tag the check runs on the held levels.
    add_checked(PhaseNone, 12'd0, 1'b1, 3'd2, PhaseU, 1);
    // Levels equal to a threshold never trigger.
    add_checked(PhaseV, 12'd1300, 1'b0, 3'd2, PhaseU, 1);
    add_checked(PhaseV, 12'd1299, 1'b1, 3'd3, PhaseW3, 2);
    add_checked(PhaseU, 12'd2200, 1'b0, 3'd3, PhaseW3, 2);
    add_checked(PhaseU, 12'd2201, 1'b1, 3'd4, PhaseV, 3);
    add_checked(PhaseW3, 12'd1300, 1'b0, 3'd4, PhaseV, 3);
    add_checked(PhaseW3, 12'd0, 1'b1, 3'd5, PhaseU, 4);
    add_checked(PhaseV, 12'd4095, 1'b1, 3'd6, PhaseW3, 5);
    add_checked(PhaseU, 12'd0, 1'b1, 3'd1, PhaseV, 6);
    add_settings(12'd4095, 12'd0, 1'b1);
    add_item(PhaseW3, 12'd4095);
    add_item(PhaseU, 12'd4095);
    add_checked(PhaseV, 12'd0, 1'b0, 3'd1, PhaseV, 6);
    add_settings(12'd0, 12'd4095, 1'b1);
    add_checked(PhaseNone, 12'd0, 1'b1, 3'd2, PhaseU, 7);
    add_checked(PhaseNone, 12'd4095, 1'b1, 3'd3, PhaseW3, 8);
    add_checked(PhaseU, 12'd0, 1'b0, 3'd3, PhaseW3, 8);
    add_checked(PhaseW3, 12'd4095, 1'b0, 3'd3, PhaseW3, 8);
    add_checked(PhaseU, 12'd1, 1'b1, 3'd4, PhaseV, 9);
    add_settings(12'd2200, 12'd1300, 1'b0);
    add_checked(PhaseW3, 12'd0, 1'b0, 3'd4, PhaseV, 9);
    add_item(PhaseV, 12'd2048);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETTINGS)
        apply_settings(directed_rows[i].high, directed_rows[i].low, directed_rows[i].run);
      else
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      h = SampleW'($urandom);
      l = SampleW'($urandom);
      r = 1'b1;
      case (p)
        0, 7: begin
          h = HighThreshReset;
          l = LowThreshReset;
        end
        2: begin
          h = SampleW'(SampleMax);
          l = '0;
        end
        3: begin
          h = '0;
          l = SampleW'(SampleMax);
        end
        4: r = 1'b0;
        5: begin
          h = SampleW'(SampleMax - $urandom_range(0, 200));
          l = SampleW'($urandom_range(0, 200));
        end
        default: ;
      endcase
      apply_settings(h, l, r);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // Idling comes and goes in stretches and stops for the final phase.
        if (k % 40 == 0) gaps_allowed = (p != RandomPhases - 1) && ($urandom_range(0, 3) != 0);
        send_item(random_item(), 1'b0, no_want);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d results under %0d register settings, %0d of them commutations.",
             results_checked, settings_applied, commutations_seen);
    $display("Mismatches: %0d, failures: %0d.", mismatches, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
